// ===== sv/viterbi_hard_decision_decoder_assert.svh =====
// Assertion macros for the decoder RTL; only vhd_back includes them.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef VITERBI_HARD_DECISION_DECODER_ASSERT_SVH
`define VITERBI_HARD_DECISION_DECODER_ASSERT_SVH
`ifndef ASSERT_OFF
`define VHD_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define VHD_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define VHD_ASSERT(label, clk, rstn, prop)
`define VHD_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== sv/vhd_pkg.sv =====
// Shared types and constants for the hard-decision Viterbi decoder.
// No dependencies.
package vhd_pkg;
  localparam int MaxConstraint = 7;
  localparam int MaxPolys      = 4;
  localparam int TrellisDepth  = 256;
  localparam int MetricWidth   = 16;
  localparam int NumStates     = 1 << (MaxConstraint - 1);
  localparam int StateW        = MaxConstraint - 1;
  localparam int ColW          = $clog2(TrellisDepth);
  localparam int CountW        = ColW + 1;
  localparam int ByteBits      = 8;
  localparam int QueueDepth    = 2;

  typedef enum logic [1:0] {
    CmdRestart = 2'd0,
    CmdSymbol  = 2'd1,
    CmdFinish  = 2'd2,
    CmdNone    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    RegConstraint = 3'd0,
    RegPolyCount  = 3'd1,
    RegPolys      = 3'd2,
    RegTail       = 3'd3,
    RegStart      = 3'd4,
    RegInitMetric = 3'd5
  } reg_e;

  // One classified command handed from the front end to the back end.
  typedef struct packed {
    cmd_e       cmd;
    logic [3:0] symbol;
  } job_t;

  typedef struct packed {
    logic [7:0]             data_byte;
    logic [3:0]             bit_count;
    logic                   last;
    logic [15:0]            error_count;
    logic [8:0]             decoded_total;
    logic                   status;
  } result_t;
endpackage

// ===== sv/vhd_front.sv =====
// Front end: accepts commands, drops unknown codes, queues the rest.
// Depends on vhd_pkg.
module vhd_front
  import vhd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command_i,
  input  logic [3:0] code_symbol_i,
  output logic       job_valid_o,
  input  logic       job_ready_i,
  output job_t       job_o
);
  job_t                           q_q [QueueDepth];
  logic [$clog2(QueueDepth)-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [$clog2(QueueDepth):0]    cnt_q, cnt_d;
  logic                           push, pop;

  assign in_ready    = (cnt_q != QueueDepth[$clog2(QueueDepth):0]);
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = q_q[rd_q];
  assign push = in_valid && in_ready && (cmd_e'(command_i) != CmdNone);
  assign pop  = job_valid_o && job_ready_i;

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + {{$clog2(QueueDepth){1'b0}}, push} - {{$clog2(QueueDepth){1'b0}}, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= '{cmd: cmd_e'(command_i), symbol: code_symbol_i};
    end
  end
endmodule

// ===== sv/vhd_back.sv =====
// Back end: add-compare-select, decision memory, traceback and byte packing.
// Depends on vhd_pkg and the assertion macro header.
`include "viterbi_hard_decision_decoder_assert.svh"
module vhd_back
  import vhd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  input  logic [2:0]  k_reg_i,
  input  logic [2:0]  n_reg_i,
  input  logic [63:0] polys_i,
  input  logic        tail_i,
  input  logic [5:0]  start_i,
  input  logic [15:0] init_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output result_t     res_o
);
  typedef enum logic [2:0] {
    StIdle, StMin, StRead, StTrace, StEmit
  } state_e;

  state_e                    state_q;
  logic [MetricWidth-1:0]    pm_q [NumStates];
  logic [CountW-1:0]         col_q;
  logic [NumStates-1:0]      dec_mem [TrellisDepth];
  logic [NumStates-1:0]      rd_word_q;
  logic [ColW-1:0]           rd_addr;
  logic [CountW-1:0]         idx_q;
  logic [StateW-1:0]         s_q, best_q;
  logic [MetricWidth-1:0]    min_q;
  logic [StateW:0]           scan_q;
  logic [TrellisDepth-1:0]   bits_q;
  logic [CountW-1:0]         nbits_q, base_q;
  logic                      out_valid_q;
  result_t                   out_q;

  logic [2:0]  k_eff, n_eff;
  logic [StateW:0] nst;
  assign k_eff = (k_reg_i == 3'd0) ? 3'd1 : k_reg_i;
  assign n_eff = (n_reg_i == 3'd0) ? 3'd1 :
                 (n_reg_i > 3'(MaxPolys)) ? 3'(MaxPolys) : n_reg_i;
  assign nst   = (StateW+1)'(1) << (k_eff - 3'd1);

  // Expected code bits for a full register value.
  function automatic logic [3:0] exp_code(input logic [2:0] k, input logic [2:0] n,
                                          input logic [63:0] polys, input logic [6:0] full);
    logic [3:0] o;
    logic [15:0] p;
    logic [6:0] r;
    o = '0;
    for (int j = 0; j < MaxPolys; j++) begin
      if (j < int'(n)) begin
        p = polys[16*(int'(n)-1-j) +: 16];
        r = '0;
        for (int b = 0; b < MaxConstraint; b++) begin
          if (b < int'(k)) r[int'(k)-1-b] = p[b];
        end
        o[j] = ^(full & r);
      end
    end
    return o;
  endfunction

  // One parallel ACS column.
  logic [MetricWidth-1:0] nxt [NumStates];
  logic [NumStates-1:0]   word;
  logic [3:0]             rx;
  always_comb begin
    logic [6:0] up;
    logic [MetricWidth:0] d1, d2;
    rx = job_i.symbol & 4'((5'd1 << n_eff) - 5'd1);
    word = '0;
    for (int i = 0; i < NumStates; i++) begin
      up = 7'(i) | 7'(nst);
      d1 = {1'b0, pm_q[i >> 1]} +
           (MetricWidth+1)'($countones(exp_code(k_eff, n_eff, polys_i, 7'(i)) ^ rx));
      d2 = {1'b0, pm_q[up[6:1]]} +
           (MetricWidth+1)'($countones(exp_code(k_eff, n_eff, polys_i, up) ^ rx));
      if (d1[MetricWidth]) d1 = {1'b0, {MetricWidth{1'b1}}};
      if (d2[MetricWidth]) d2 = {1'b0, {MetricWidth{1'b1}}};
      if (d2 < d1) begin
        nxt[i] = d2[MetricWidth-1:0]; word[i] = 1'b1;
      end else begin
        nxt[i] = d1[MetricWidth-1:0];
      end
    end
  end

  logic full_col, start_ok;
  assign full_col = (col_q == CountW'(TrellisDepth));
  assign start_ok = {1'b0, start_i} < nst;
  assign job_ready_o = (state_q == StIdle) && !(out_valid_q && !res_ready_i);
  assign res_valid_o = out_valid_q;
  assign res_o = out_q;
  assign rd_addr = ColW'(idx_q - CountW'(1));

  // A rejected symbol or a packed byte loads the output register.
  logic rej_fire, emit_fire;
  assign rej_fire  = (state_q == StIdle) && job_valid_i && job_ready_o &&
                     (job_i.cmd == CmdSymbol) && full_col;
  assign emit_fire = (state_q == StEmit) && (!out_valid_q || res_ready_i);

  logic [CountW-1:0] extra, nbits_c;
  assign extra   = tail_i ? CountW'(k_eff - 3'd1) : '0;
  assign nbits_c = (col_q > extra) ? col_q - extra : '0;

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && job_valid_i && job_ready_o &&
        job_i.cmd == CmdSymbol && !full_col) begin
      dec_mem[col_q[ColW-1:0]] <= word;
    end
    rd_word_q <= dec_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      col_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumStates; i++) pm_q[i] <= (i == 0) ? '0 : MetricWidth'(1024);
      idx_q <= '0; s_q <= '0; best_q <= '0; min_q <= '0; scan_q <= '0;
      bits_q <= '0; nbits_q <= '0; base_q <= '0; out_q <= '0;
    end else begin
      if (rej_fire || emit_fire) out_valid_q <= 1'b1;
      else if (out_valid_q && res_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (job_valid_i && job_ready_o) begin
            unique case (job_i.cmd)
              CmdRestart: begin
                if (start_ok) begin
                  for (int i = 0; i < NumStates; i++)
                    if (i < int'(nst)) pm_q[i] <= (i == int'(start_i)) ? '0 : init_i;
                  col_q <= '0;
                end
              end
              CmdSymbol: begin
                if (full_col) begin
                  out_q <= '{default: '0, status: 1'b1};
                end else begin
                  for (int i = 0; i < NumStates; i++)
                    if (i < int'(nst)) pm_q[i] <= nxt[i];
                  col_q <= col_q + 1'b1;
                end
              end
              CmdFinish: begin
                min_q <= pm_q[0]; best_q <= '0; scan_q <= (StateW+1)'(1);
                state_q <= StMin;
              end
              default: ;
            endcase
          end
        end
        StMin: begin
          if (scan_q < nst) begin
            if (pm_q[scan_q[StateW-1:0]] < min_q) begin
              min_q <= pm_q[scan_q[StateW-1:0]]; best_q <= scan_q[StateW-1:0];
            end
            scan_q <= scan_q + 1'b1;
          end else begin
            s_q <= best_q; idx_q <= col_q;
            nbits_q <= nbits_c; base_q <= '0;
            state_q <= (col_q == '0) ? StEmit : StRead;
          end
        end
        StRead: state_q <= StTrace;
        StTrace: begin
          bits_q[rd_addr] <= s_q[0];
          s_q <= rd_word_q[s_q] ? StateW'(({1'b0, s_q} | nst) >> 1) : StateW'(s_q >> 1);
          idx_q <= idx_q - 1'b1;
          state_q <= (idx_q == CountW'(1)) ? StEmit : StRead;
        end
        StEmit: begin
          if (emit_fire) begin
            logic [CountW-1:0] rem;
            logic [3:0] cnt;
            rem = nbits_q - base_q;
            cnt = (rem > CountW'(ByteBits)) ? 4'(ByteBits) : 4'(rem);
            out_q.data_byte <= bits_q[base_q[ColW-1:0] +: ByteBits] &
                               8'((9'd1 << cnt) - 9'd1);
            out_q.bit_count <= cnt;
            out_q.last <= (rem <= CountW'(ByteBits));
            out_q.error_count <= min_q;
            out_q.decoded_total <= 9'(nbits_q);
            out_q.status <= 1'b0;
            base_q <= base_q + CountW'(ByteBits);
            if (rem <= CountW'(ByteBits)) state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `VHD_ASSERT(a_col_bound, clk_i, rst_ni, col_q <= CountW'(TrellisDepth))
  `VHD_ASSERT(a_hold, clk_i, rst_ni, out_valid_q && !res_ready_i |=> $stable(out_q))
  `VHD_ASSERT(a_trace_col, clk_i, rst_ni, (state_q == StTrace) |-> (idx_q != '0))
endmodule

// ===== sv/viterbi_hard_decision_decoder.sv =====
// Hard-decision Viterbi decoder, top level: config registers, front and back.
// Depends on vhd_pkg, vhd_front, vhd_back.
// Restart and symbol transfers are handled by the back end while it is idle (ACS is one
// parallel column over 64 states). Finish runs a serial minimum scan, then a
// traceback that reads the decision RAM one column per StRead/StTrace pair, then
// packs the bytes. Reset loads the default registers.
module viterbi_hard_decision_decoder
  import vhd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command_i,
  input  logic [3:0]  code_symbol_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte_o,
  output logic [3:0]  bit_count_o,
  output logic        last_o,
  output logic [15:0] error_count_o,
  output logic [8:0]  decoded_total_o,
  output logic        status_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  // Configuration registers; the user must write them only while the block is idle (not enforced).
  logic [2:0]  k_q, n_q;
  logic [63:0] polys_q;
  logic        tail_q;
  logic [5:0]  start_q;
  logic [15:0] init_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= 3'd3; n_q <= 3'd2; polys_q <= 64'd458757;
      tail_q <= 1'b1; start_q <= '0; init_q <= 16'd1024;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        RegConstraint: k_q <= cfg_data_i[2:0];
        RegPolyCount:  n_q <= cfg_data_i[2:0];
        RegPolys:      polys_q <= cfg_data_i;
        RegTail:       tail_q <= cfg_data_i[0];
        RegStart:      start_q <= cfg_data_i[5:0];
        RegInitMetric: init_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic    job_valid, job_ready;
  job_t    job;
  result_t res;

  vhd_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .command_i, .code_symbol_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  vhd_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .k_reg_i(k_q), .n_reg_i(n_q), .polys_i(polys_q), .tail_i(tail_q),
    .start_i(start_q), .init_i(init_q),
    .res_valid_o(out_valid), .res_ready_i(out_ready), .res_o(res)
  );

  assign data_byte_o     = res.data_byte;
  assign bit_count_o     = res.bit_count;
  assign last_o          = res.last;
  assign error_count_o   = res.error_count;
  assign decoded_total_o = res.decoded_total;
  assign status_o        = res.status;
endmodule

// ===== tb/tb_viterbi_hard_decision_decoder.sv =====
// Self-checking testbench for the hard-decision Viterbi decoder top level.
// Depends on vhd_pkg and viterbi_hard_decision_decoder, which in turn needs vhd_front and vhd_back.
`timescale 1ns / 100ps

module tb_viterbi_hard_decision_decoder;
  import vhd_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command_i;
  logic [3:0]  code_symbol_i;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  data_byte_o;
  logic [3:0]  bit_count_o;
  logic        last_o;
  logic [15:0] error_count_o;
  logic [8:0]  decoded_total_o;
  logic        status_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  viterbi_hard_decision_decoder DUT (.*);

  // Settle time after the last result before a register write or the end.
  // A finish over a full trellis at the largest k scans 64 states, traces back 256 columns
  // and emits 32 bytes, and restarts or symbols can still be in flight behind it.
  localparam int DrainCycles = 800;
  localparam int HoldCycles  = 400;

  // Register copies, kept in step with every write to the block.
  bit [2:0]  cl_reg;
  bit [2:0]  np_reg;
  bit [63:0] polys_reg;
  bit        tail_reg;
  bit [5:0]  start_reg;
  bit [15:0] init_reg;

  // Decoder state as the block should hold it.
  bit [15:0] metric_q [NumStates];
  bit [63:0] decision_q [TrellisDepth];
  int        columns_q;

  result_t   pending_bytes [$];
  int        errors;
  int        items_sent;
  bit        quiet;       // disables idling on both sides
  bit        hold_start;  // asks the receiver for one long hold-off
  int        hold_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int eff_k();
    if (cl_reg < 1) return 1;
    if (cl_reg > MaxConstraint) return MaxConstraint;
    return cl_reg;
  endfunction

  function automatic int eff_n();
    if (np_reg < 1) return 1;
    if (np_reg > MaxPolys) return MaxPolys;
    return np_reg;
  endfunction

  // Code bits that a k-bit register value should produce. Code bit j uses
  // polynomial n-1-j with its low k bits reversed.
  function automatic bit [3:0] branch_code(int k, int n, bit [6:0] full);
    bit [3:0]  code;
    bit [15:0] poly;
    bit [6:0]  taps;
    code = '0;
    for (int j = 0; j < n; j++) begin
      poly = polys_reg[16 * (n - 1 - j) +: 16];
      taps = '0;
      for (int b = 0; b < k; b++) taps[k - 1 - b] = poly[b];
      code[j] = ^(full & taps);
    end
    return code;
  endfunction

  function automatic bit [15:0] clamp_metric(int unsigned v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  // One add-compare-select column; ties keep the lower predecessor.
  function automatic void acs_column(bit [3:0] sym);
    int        k, n, nst;
    bit [3:0]  rx;
    bit [15:0] nxt [NumStates];
    bit [15:0] m_lo, m_hi;
    bit [63:0] word;
    k = eff_k();
    n = eff_n();
    nst = 1 << (k - 1);
    rx = sym & ((4'd1 << n) - 4'd1);
    word = '0;
    for (int i = 0; i < nst; i++) begin
      m_lo = clamp_metric(metric_q[i >> 1] + $countones(branch_code(k, n, i) ^ rx));
      m_hi = clamp_metric(metric_q[(i | nst) >> 1] +
                          $countones(branch_code(k, n, i | nst) ^ rx));
      if (m_hi < m_lo) begin
        nxt[i] = m_hi;
        word[i] = 1'b1;
      end else begin
        nxt[i] = m_lo;
      end
    end
    for (int i = 0; i < nst; i++) metric_q[i] = nxt[i];
    decision_q[columns_q % TrellisDepth] = word;
    columns_q++;
  endfunction

  // Minimum search, traceback and byte packing for a finish command.
  function automatic void trace_back();
    int        k, nst, s, tail, nbits, nbytes, cnt;
    bit [15:0] best;
    bit        dec_bits [TrellisDepth];
    result_t   r;
    k = eff_k();
    nst = 1 << (k - 1);
    s = 0;
    best = metric_q[0];
    for (int i = 1; i < nst; i++) begin
      if (metric_q[i] < best) begin
        best = metric_q[i];
        s = i;
      end
    end
    for (int i = columns_q - 1; i >= 0; i--) begin
      dec_bits[i % TrellisDepth] = s[0];
      s = decision_q[i % TrellisDepth][s & 63] ? ((s | nst) >> 1) : (s >> 1);
    end
    tail = tail_reg ? k - 1 : 0;
    nbits = (columns_q > tail) ? columns_q - tail : 0;
    nbytes = (nbits + ByteBits - 1) / ByteBits;
    if (nbytes == 0) nbytes = 1;
    for (int b = 0; b < nbytes; b++) begin
      cnt = nbits - b * ByteBits;
      if (cnt < 0) cnt = 0;
      if (cnt > ByteBits) cnt = ByteBits;
      r = '0;
      for (int i = 0; i < cnt; i++) r.data_byte[i] = dec_bits[(b * ByteBits + i) % TrellisDepth];
      r.bit_count = cnt;
      r.last = (b + 1 == nbytes);
      r.error_count = best;
      r.decoded_total = nbits;
      pending_bytes.push_back(r);
    end
  endfunction

  function automatic void predict_command(cmd_e cmd, bit [3:0] sym);
    int      nst;
    result_t r;
    case (cmd)
      CmdRestart: begin
        nst = 1 << (eff_k() - 1);
        // An out-of-range start state leaves the trellis untouched.
        if (start_reg < nst) begin
          for (int i = 0; i < nst; i++) metric_q[i] = (i == start_reg) ? 16'd0 : init_reg;
          columns_q = 0;
        end
      end
      CmdSymbol: begin
        if (columns_q >= TrellisDepth) begin
          r = '0;
          r.status = 1'b1;
          pending_bytes.push_back(r);
        end else begin
          acs_column(sym);
        end
      end
      CmdFinish: trace_back();
      default: ;
    endcase
  endfunction

  // Offers one command and waits for its transfer. Valid stays high on return
  // so that a following call can present the next item without a bubble.
  task automatic send_item(cmd_e cmd, bit [3:0] sym);
    if (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    command_i     <= cmd;
    code_symbol_i <= sym;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predict_command(cmd, sym);
    items_sent++;
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every expected byte has come back and the block has drained.
  task automatic wait_drained();
    stop_input();
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, bit [63:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      RegConstraint: cl_reg    = value[2:0];
      RegPolyCount:  np_reg    = value[2:0];
      RegPolys:      polys_reg = value;
      RegTail:       tail_reg  = value[0];
      RegStart:      start_reg = value[5:0];
      RegInitMetric: init_reg  = value[15:0];
      default: ;
    endcase
  endtask

  // Writes the whole register set; only called while the block is idle.
  task automatic configure(bit [63:0] k, bit [63:0] n, bit [63:0] polys,
                           bit [63:0] tail, bit [63:0] start, bit [63:0] init);
    wait_drained();
    write_reg(RegConstraint, k);
    write_reg(RegPolyCount, n);
    write_reg(RegPolys, polys);
    write_reg(RegTail, tail);
    write_reg(RegStart, start);
    write_reg(RegInitMetric, init);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_symbols(int count);
    for (int i = 0; i < count; i++) send_item(CmdSymbol, $urandom_range(15));
  endtask

  // Receiver: checks each transfer against the oldest expected byte and
  // drives ready with random stalls, plus one long hold-off when asked.
  always @(posedge clk_i) begin
    result_t want;
    if (out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected result, data_byte %h status %b",
                 $time, data_byte_o, status_o);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (data_byte_o !== want.data_byte) begin
          $display("%0t: data_byte expected %h actual %h", $time, want.data_byte, data_byte_o);
          errors++;
        end
        if (bit_count_o !== want.bit_count) begin
          $display("%0t: bit_count expected %0d actual %0d", $time, want.bit_count,
                   bit_count_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, last_o);
          errors++;
        end
        if (error_count_o !== want.error_count) begin
          $display("%0t: error_count expected %0d actual %0d", $time, want.error_count,
                   error_count_o);
          errors++;
        end
        if (decoded_total_o !== want.decoded_total) begin
          $display("%0t: decoded_total expected %0d actual %0d", $time,
                   want.decoded_total, decoded_total_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %b actual %b", $time, want.status, status_o);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_start) begin
      hold_start = 1'b0;
      hold_left = HoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 15);
    end
  end

  // Default registers straight out of reset: an empty finish, then a short
  // run that is shorter than the tail, then every symbol value.
  task automatic test_reset_defaults();
    send_item(CmdFinish, 4'd0);
    send_item(CmdSymbol, 4'd3);
    send_item(CmdFinish, 4'd0);
    for (int s = 0; s < 16; s++) send_item(CmdSymbol, s);
    send_item(CmdFinish, 4'd15);
    // Unknown commands must not disturb the trellis.
    send_item(CmdNone, 4'd15);
    send_item(CmdFinish, 4'd0);
  endtask

  // Out-of-range sizes, tail off, an ignored restart and saturated metrics.
  task automatic test_config_corners();
    configure(0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 16'hFFFF);
    send_item(CmdRestart, 4'd0);
    send_symbols(5);
    send_item(CmdFinish, 4'd0);
    configure(7, 7, 64'h5B6D_4F79_6D5B_794F, 1, 63, 0);
    send_item(CmdRestart, 4'd0);
    send_symbols(12);
    send_item(CmdFinish, 4'd0);
    // Start state beyond 2^(k-1): the restart is ignored and the run goes on.
    configure(3, 4, 64'h0007_0005_0003_0006, 1, 5, 16'hFFFF);
    send_item(CmdRestart, 4'd0);
    send_symbols(4);
    send_item(CmdFinish, 4'd0);
    configure(2, 5, 64'hA5A5_5A5A_0003_0002, 0, 1, 16'hFFFF);
    send_item(CmdRestart, 4'd0);
    send_symbols(6);
    send_item(CmdFinish, 4'd0);
  endtask

  // Fills the trellis with no idling on either side, then finishes under a
  // long receiver hold-off while more symbols and a second finish keep
  // arriving behind it.
  task automatic test_full_trellis();
    configure(7, 2, 64'h0000_0000_004F_006D, 0, 0, 16'd7);
    quiet = 1'b1;
    send_item(CmdRestart, 4'd0);
    send_symbols(TrellisDepth + 2);
    quiet = 1'b0;
    hold_start = 1'b1;
    send_item(CmdFinish, 4'd0);
    send_symbols(3);
    send_item(CmdFinish, 4'd0);
  endtask

  // Random configurations, each followed by a restart, a run of symbols with
  // some noise, and a finish. Most runs use small k to keep finishes short.
  task automatic test_random_runs();
    int        k, run_len;
    bit [63:0] start;
    int        target;
    target = items_sent + 40;
    while (items_sent < target) begin
      k = ($urandom_range(99) < 70) ? $urandom_range(1, 4) : $urandom_range(0, 7);
      start = ($urandom_range(9) == 0) ? $urandom_range(63)
            : $urandom_range(0, (1 << ((k < 1 ? 1 : k) - 1)) - 1);
      quiet = ($urandom_range(3) == 0);
      configure(k, $urandom_range(7), {$urandom, $urandom}, $urandom_range(1),
                start, ($urandom_range(3) == 0) ? 64'hFFFF : $urandom_range(300));
      send_item(CmdRestart, $urandom_range(15));
      run_len = $urandom_range(1, 30);
      for (int i = 0; i < run_len; i++) begin
        case ($urandom_range(19))
          0: send_item(CmdNone, $urandom_range(15));
          1: send_item(CmdFinish, $urandom_range(15));
          default: send_item(CmdSymbol, $urandom_range(15));
        endcase
      end
      send_item(CmdFinish, $urandom_range(15));
    end
    quiet = 1'b0;
  endtask

  initial begin
    in_valid      <= 1'b0;
    command_i     <= CmdNone;
    code_symbol_i <= '0;
    out_ready     <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= RegConstraint;
    cfg_data_i    <= '0;
    cl_reg     = 3;
    np_reg     = 2;
    polys_reg  = 64'd458757;
    tail_reg   = 1'b1;
    start_reg  = 0;
    init_reg   = 16'd1024;
    for (int i = 0; i < NumStates; i++) metric_q[i] = (i == 0) ? 16'd0 : 16'd1024;
    columns_q  = 0;
    errors     = 0;
    items_sent = 0;
    quiet      = 1'b0;
    hold_start = 1'b0;
    hold_left  = 0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_config_corners();
    test_full_trellis();
    test_random_runs();

    wait_drained();
    if (errors == 0 && pending_bytes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
